>>> hdl/bmu_pkg.sv
// ----------------------------------------------------------------------------
// bmu_pkg
// Shared sizes, codes and types for the breakpoint match unit.
// ----------------------------------------------------------------------------
package bmu_pkg;

  localparam int ENTRIES = 16;
  localparam int ADDR_W  = 32;
  localparam int DEPTH_W = 16;
  localparam int COUNT_W = 16;

  localparam logic [1:0] OP_EXEC = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_STEP = 2'd2;

  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_STEP = 2'd1;
  localparam logic [1:0] CAUSE_BKPT = 2'd2;

  // Item broadcast to every cell while it walks the chain.
  typedef struct packed {
    logic               lookup;
    logic               insert;
    logic [ADDR_W-1:0]  addr;
    logic [DEPTH_W-1:0] depth;
    logic               any;
    logic [COUNT_W-1:0] count;
    logic               temp;
  } item_t;

  // Token handed from cell to cell.
  typedef struct packed {
    logic active;
    logic hit;
    logic matched;
    logic free_seen;
  } sweep_t;

endpackage

>>> hdl/breakpoint_match_unit_top.sv
// ----------------------------------------------------------------------------
// breakpoint_match_unit_top
// Breakpoint table with hit counters and single-step flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one operation per transfer:
//   executed instruction, set breakpoint, or stop-at-next request. Every
//   operation returns exactly one result transfer on out_valid/out_stall.
//   Table operations (instruction with a nonzero address and the step flag
//   clear, set with a nonzero address) send a token through a chain of
//   ENTRIES cells, one cell per cycle; the result is registered once the
//   token leaves the last cell. All other operations write their result
//   register straight from the input transfer. One operation is in flight
//   at a time: a new item is not taken until the previous result has moved
//   to the output register. in_stall is high while an item is in flight or
//   its result waits for the output register.
//   A new item is taken while the previous result sits in the output
//   register under out_stall; the output payload holds while stalled.
//   Reset (rst_n low, synchronous) empties the table and arms the step flag, so
//   the first executed nonzero-address instruction halts with single-step cause.
// ----------------------------------------------------------------------------
module breakpoint_match_unit_top import bmu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [ADDR_W-1:0]  in_address,
  input  logic [DEPTH_W-1:0] in_stack_depth,
  input  logic               in_depth_any,
  input  logic [COUNT_W-1:0] in_hit_count,
  input  logic               in_temporary,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_halt,
  output logic [1:0]         out_halt_cause,
  output logic               out_table_full
);

  logic        step_armed_r, step_armed_nxt;
  logic        walking_r, walking_nxt;
  logic        launch_r, launch_nxt;
  logic        pend_r, pend_nxt;
  logic        res_halt_r, res_halt_nxt;
  logic [1:0]  res_cause_r, res_cause_nxt;
  logic        res_full_r, res_full_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_halt_r, out_halt_nxt;
  logic [1:0]  out_cause_r, out_cause_nxt;
  logic        out_full_r, out_full_nxt;
  item_t       item_r, item_nxt;

  sweep_t      chain [ENTRIES+1];
  logic        accept;
  logic        addr_nz;
  logic        lookup;
  logic        insert;
  logic        commit;
  logic        unload;
  sweep_t      tail;

  assign in_stall = walking_r | pend_r;
  assign accept   = in_valid && !in_stall;
  assign addr_nz  = (in_address != '0);
  assign lookup   = (in_op == OP_EXEC) && addr_nz && !step_armed_r;
  assign insert   = (in_op == OP_SET) && addr_nz;

  assign chain[0].active    = launch_r;
  assign chain[0].hit       = 1'b0;
  assign chain[0].matched   = 1'b0;
  assign chain[0].free_seen = 1'b0;
  assign tail               = chain[ENTRIES];

  // new address goes to the lowest free cell only when no cell matched
  assign commit = tail.active && item_r.insert && !tail.matched && tail.free_seen;
  assign unload = pend_r && (!out_valid_r || !out_stall);

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bmu_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .item      (item_r),
      .start     (accept),
      .commit    (commit),
      .sweep_in  (chain[g]),
      .sweep_out (chain[g+1])
    );
  end

  always_comb begin
    step_armed_nxt = step_armed_r;
    walking_nxt    = walking_r;
    launch_nxt     = 1'b0;
    pend_nxt       = pend_r;
    res_halt_nxt   = res_halt_r;
    res_cause_nxt  = res_cause_r;
    res_full_nxt   = res_full_r;
    item_nxt       = item_r;
    out_valid_nxt  = out_valid_r;
    out_halt_nxt   = out_halt_r;
    out_cause_nxt  = out_cause_r;
    out_full_nxt   = out_full_r;

    if (accept) begin
      item_nxt.lookup = lookup;
      item_nxt.insert = insert;
      item_nxt.addr   = in_address;
      item_nxt.depth  = in_stack_depth;
      item_nxt.any    = in_depth_any;
      item_nxt.count  = (in_hit_count == '0) ? COUNT_W'(1) : in_hit_count;
      item_nxt.temp   = in_temporary;
      res_halt_nxt    = 1'b0;
      res_cause_nxt   = CAUSE_NONE;
      res_full_nxt    = 1'b0;
      if (lookup || insert) begin
        walking_nxt = 1'b1;
        launch_nxt  = 1'b1;
      end else begin
        pend_nxt = 1'b1;
        if (in_op == OP_EXEC && addr_nz) begin
          step_armed_nxt = 1'b0;
          res_halt_nxt   = 1'b1;
          res_cause_nxt  = CAUSE_STEP;
        end else if (in_op == OP_STEP) begin
          step_armed_nxt = 1'b1;
        end
      end
    end

    if (tail.active) begin
      walking_nxt   = 1'b0;
      pend_nxt      = 1'b1;
      res_halt_nxt  = tail.hit;
      res_cause_nxt = tail.hit ? CAUSE_BKPT : CAUSE_NONE;
      res_full_nxt  = item_r.insert && !tail.matched && !tail.free_seen;
    end

    if (unload) begin
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      out_halt_nxt  = res_halt_r;
      out_cause_nxt = res_cause_r;
      out_full_nxt  = res_full_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_armed_r <= 1'b1;
      walking_r    <= 1'b0;
      launch_r     <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      step_armed_r <= step_armed_nxt;
      walking_r    <= walking_nxt;
      launch_r     <= launch_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    res_halt_r  <= res_halt_nxt;
    res_cause_r <= res_cause_nxt;
    res_full_r  <= res_full_nxt;
    item_r      <= item_nxt;
    out_halt_r  <= out_halt_nxt;
    out_cause_r <= out_cause_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_halt       = out_halt_r;
  assign out_halt_cause = out_cause_r;
  assign out_table_full = out_full_r;

endmodule

>>> hdl/bmu_cell.sv
// ----------------------------------------------------------------------------
// bmu_cell
// One breakpoint entry plus its stage of the sweep token chain.
// ----------------------------------------------------------------------------
module bmu_cell import bmu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  item_t  item,
  input  logic   start,
  input  logic   commit,
  input  sweep_t sweep_in,
  output sweep_t sweep_out
);

  logic               valid_r, valid_nxt;
  logic               cand_r, cand_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               any_r, any_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] reload_r, reload_nxt;
  logic               temp_r, temp_nxt;
  sweep_t             sweep_r, sweep_nxt;

  logic               match;
  logic               hit_here;
  logic               fire;
  logic               set_here;
  logic               write;
  logic [COUNT_W-1:0] left;

  always_comb begin
    match    = valid_r && (addr_r == item.addr);
    hit_here = sweep_in.active && item.lookup && match && (any_r || depth_r == item.depth);
    left     = (rem_r == '0) ? '0 : rem_r - COUNT_W'(1);
    fire     = hit_here && (left == '0);
    set_here = sweep_in.active && item.insert && match;
    // commit lands on the first free cell seen during the walk
    write    = set_here || (commit && cand_r);

    valid_nxt  = valid_r;
    addr_nxt   = addr_r;
    depth_nxt  = depth_r;
    any_nxt    = any_r;
    rem_nxt    = rem_r;
    reload_nxt = reload_r;
    temp_nxt   = temp_r;
    if (write) begin
      valid_nxt  = 1'b1;
      addr_nxt   = item.addr;
      depth_nxt  = item.depth;
      any_nxt    = item.any;
      rem_nxt    = item.count;
      reload_nxt = item.count;
      temp_nxt   = item.temp;
    end else if (hit_here) begin
      if (fire) begin
        rem_nxt = reload_r;
        if (temp_r) begin
          valid_nxt = 1'b0;
        end
      end else begin
        rem_nxt = left;
      end
    end

    cand_nxt = cand_r;
    if (start) begin
      cand_nxt = 1'b0;
    end else if (sweep_in.active && !valid_r && !sweep_in.free_seen) begin
      cand_nxt = 1'b1;
    end

    sweep_nxt.active    = sweep_in.active;
    sweep_nxt.hit       = sweep_in.hit | fire;
    sweep_nxt.matched   = sweep_in.matched | set_here;
    sweep_nxt.free_seen = sweep_in.free_seen | !valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r        <= 1'b0;
      cand_r         <= 1'b0;
      sweep_r.active <= 1'b0;
    end else begin
      valid_r        <= valid_nxt;
      cand_r         <= cand_nxt;
      sweep_r.active <= sweep_nxt.active;
    end
    sweep_r.hit       <= sweep_nxt.hit;
    sweep_r.matched   <= sweep_nxt.matched;
    sweep_r.free_seen <= sweep_nxt.free_seen;
    addr_r            <= addr_nxt;
    depth_r           <= depth_nxt;
    any_r             <= any_nxt;
    rem_r             <= rem_nxt;
    reload_r          <= reload_nxt;
    temp_r            <= temp_nxt;
  end

  assign sweep_out = sweep_r;

endmodule

>>> tb/bmu_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmu_result_checker
// Watches both channels of the breakpoint match unit. Every input transfer
// runs through a local breakpoint table and step flag to produce the expected
// verdict, and every output transfer is compared field by field with the
// oldest expected verdict.
// ----------------------------------------------------------------------------
module bmu_result_checker import bmu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [ADDR_W-1:0]  in_address,
  input  logic [DEPTH_W-1:0] in_stack_depth,
  input  logic               in_depth_any,
  input  logic [COUNT_W-1:0] in_hit_count,
  input  logic               in_temporary,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_halt,
  input  logic [1:0]         out_halt_cause,
  input  logic               out_table_full,
  output int                 mismatches,
  output int                 pending
);

  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic       halt;
    logic [1:0] cause;
    logic       full;
  } verdict_t;

  // Local copy of the breakpoint table
  logic               bp_valid  [ENTRIES];
  logic [ADDR_W-1:0]  bp_addr   [ENTRIES];
  logic [DEPTH_W-1:0] bp_depth  [ENTRIES];
  logic               bp_any    [ENTRIES];
  logic [COUNT_W-1:0] bp_left   [ENTRIES];
  logic [COUNT_W-1:0] bp_reload [ENTRIES];
  logic               bp_temp   [ENTRIES];
  logic               step_flag;

  verdict_t expected_verdicts[$];
  int       result_no  = 0;
  int       fail_total = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_total < PRINT_CAP)
      $display("mismatch at result %0d: %s", result_no, msg);
    fail_total++;
  endtask

  function automatic int lookup_slot(input logic [ADDR_W-1:0] a);
    for (int i = 0; i < ENTRIES; i++)
      if (bp_valid[i] && bp_addr[i] == a)
        return i;
    return -1;
  endfunction

  function automatic verdict_t predict_verdict(
    input logic [1:0]         op,
    input logic [ADDR_W-1:0]  addr,
    input logic [DEPTH_W-1:0] depth,
    input logic               any,
    input logic [COUNT_W-1:0] count,
    input logic               temp
  );
    verdict_t           v;
    int                 slot;
    logic [COUNT_W-1:0] left;
    logic [COUNT_W-1:0] cnt;
    v = '0;
    case (op)
      OP_EXEC: begin
        if (addr != '0) begin
          if (step_flag) begin
            // stop-at-next wins and leaves the counters alone
            step_flag = 1'b0;
            v.halt    = 1'b1;
            v.cause   = CAUSE_STEP;
          end else begin
            slot = lookup_slot(addr);
            if (slot >= 0 && (bp_any[slot] || bp_depth[slot] == depth)) begin
              left = (bp_left[slot] == '0) ? '0 : bp_left[slot] - COUNT_W'(1);
              if (left != '0) begin
                bp_left[slot] = left;
              end else begin
                bp_left[slot] = bp_reload[slot];
                if (bp_temp[slot])
                  bp_valid[slot] = 1'b0;
                v.halt  = 1'b1;
                v.cause = CAUSE_BKPT;
              end
            end
          end
        end
      end
      OP_SET: begin
        if (addr != '0) begin
          cnt  = (count == '0) ? COUNT_W'(1) : count;
          slot = lookup_slot(addr);
          // no match: lowest free entry
          for (int k = ENTRIES - 1; k >= 0; k--)
            if (lookup_slot(addr) < 0 && !bp_valid[k])
              slot = k;
          if (slot < 0) begin
            v.full = 1'b1;
          end else begin
            bp_valid[slot]  = 1'b1;
            bp_addr[slot]   = addr;
            bp_depth[slot]  = depth;
            bp_any[slot]    = any;
            bp_left[slot]   = cnt;
            bp_reload[slot] = cnt;
            bp_temp[slot]   = temp;
          end
        end
      end
      OP_STEP: step_flag = 1'b1;
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++)
        bp_valid[i] = 1'b0;
      step_flag = 1'b1;
      expected_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = expected_verdicts.pop_front();
          if (out_halt !== want.halt)
            report_mismatch($sformatf("halt got %b expected %b", out_halt, want.halt));
          if (out_halt_cause !== want.cause)
            report_mismatch($sformatf("halt_cause got %0d expected %0d",
                                      out_halt_cause, want.cause));
          if (out_table_full !== want.full)
            report_mismatch($sformatf("table_full got %b expected %b",
                                      out_table_full, want.full));
        end
        result_no++;
      end
      if (in_valid && !in_stall)
        expected_verdicts.push_back(predict_verdict(in_op, in_address, in_stack_depth,
                                                    in_depth_any, in_hit_count,
                                                    in_temporary));
    end
    pending    <= expected_verdicts.size();
    mismatches <= fail_total;
  end

endmodule

>>> tb/breakpoint_match_unit_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// breakpoint_match_unit_top_test
// Drives the breakpoint match unit with a directed sequence (null addresses,
// single step, depth mismatch, counting, replacement, temporary removal, full
// table, undefined op) and then with bursts of random operations over a small
// address pool, under random output stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module breakpoint_match_unit_top_test import bmu_pkg::*;;

  localparam logic [1:0] OP_UNDEF    = 2'd3;
  localparam int         RANDOM_ITEMS = 1050;
  localparam int         POOL_SIZE    = 22;
  localparam int         CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [1:0]         op;
    logic [ADDR_W-1:0]  address;
    logic [DEPTH_W-1:0] depth;
    logic               any;
    logic [COUNT_W-1:0] count;
    logic               temp;
  } bp_req_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_LONG, STALL_LIGHT} stall_mode_t;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [1:0]         in_op          = OP_EXEC;
  logic [ADDR_W-1:0]  in_address     = '0;
  logic [DEPTH_W-1:0] in_stack_depth = '0;
  logic               in_depth_any   = 1'b0;
  logic [COUNT_W-1:0] in_hit_count   = '0;
  logic               in_temporary   = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic               out_halt;
  logic [1:0]         out_halt_cause;
  logic               out_table_full;

  int mismatches;
  int pending;
  int cycle_count = 0;

  logic [ADDR_W-1:0]  addr_pool [POOL_SIZE];
  logic [DEPTH_W-1:0] common_depth;

  always #6 clk = ~clk;

  breakpoint_match_unit_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_address     (in_address),
    .in_stack_depth (in_stack_depth),
    .in_depth_any   (in_depth_any),
    .in_hit_count   (in_hit_count),
    .in_temporary   (in_temporary),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_halt       (out_halt),
    .out_halt_cause (out_halt_cause),
    .out_table_full (out_table_full)
  );

  bmu_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_address     (in_address),
    .in_stack_depth (in_stack_depth),
    .in_depth_any   (in_depth_any),
    .in_hit_count   (in_hit_count),
    .in_temporary   (in_temporary),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_halt       (out_halt),
    .out_halt_cause (out_halt_cause),
    .out_table_full (out_table_full),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  // Receiver stall pattern: a mode is drawn at random and held for a random span before the next draw
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          seg_left   = 0;
  logic        seg_val    = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
        STALL_LONG: begin
          if (seg_left == 0) begin
            seg_val  = ~seg_val;
            seg_left = $urandom_range(1, 24);
          end
          seg_left--;
          out_stall <= seg_val;
        end
        default:     out_stall <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic bp_req_t mk_req(input logic [1:0] op, input logic [ADDR_W-1:0] a,
                                     input logic [DEPTH_W-1:0] d, input logic any,
                                     input logic [COUNT_W-1:0] c, input logic temp);
    bp_req_t r;
    r.op      = op;
    r.address = a;
    r.depth   = d;
    r.any     = any;
    r.count   = c;
    r.temp    = temp;
    return r;
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return DEPTH_W'(1);
      2:       return '1;
      5:       return DEPTH_W'($urandom);
      default: return common_depth;
    endcase
  endfunction

  function automatic bp_req_t random_req();
    bp_req_t r;
    int      roll;
    int      sel;
    r.op      = OP_UNDEF;
    r.address = ADDR_W'($urandom);
    r.depth   = DEPTH_W'($urandom);
    r.any     = 1'($urandom_range(0, 1));
    r.count   = COUNT_W'($urandom);
    r.temp    = 1'($urandom_range(0, 1));
    roll      = $urandom_range(0, 99);
    sel       = $urandom_range(0, 99);
    if (roll < 58) begin
      r.op    = OP_EXEC;
      r.depth = pick_depth();
      if (sel < 85)
        r.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (sel < 95)
        r.address = ADDR_W'($urandom);
      else
        r.address = '0;
    end else if (roll < 88) begin
      r.op    = OP_SET;
      r.depth = pick_depth();
      // stray addresses can never trigger, so they stay rare
      if (sel < 96)
        r.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (sel < 98)
        r.address = '0;
      sel = $urandom_range(0, 9);
      if (sel < 7)
        r.count = COUNT_W'($urandom_range(1, 3));
      else if (sel == 7)
        r.count = '0;
      else if (sel == 8)
        r.count = '1;
    end else if (roll < 96) begin
      r.op = OP_STEP;
    end
    return r;
  endfunction

  task automatic send_req(input bp_req_t r);
    in_valid       <= 1'b1;
    in_op          <= r.op;
    in_address     <= r.address;
    in_stack_depth <= r.depth;
    in_depth_any   <= r.any;
    in_hit_count   <= r.count;
    in_temporary   <= r.temp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    for (int i = 0; i < 16; i++)
      addr_pool[i] = ADDR_W'(32'h2000 + i);
    addr_pool[16] = '1;
    addr_pool[17] = ADDR_W'(32'h1000);
    for (int i = 18; i < POOL_SIZE; i++)
      addr_pool[i] = ADDR_W'($urandom_range(32'hFFFF_FFFF, 1));
    common_depth = DEPTH_W'($urandom);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    send_req(mk_req(OP_EXEC, '0, '0, 1'b0, '0, 1'b0));           // null address keeps step
    send_req(mk_req(OP_EXEC, 32'h1000, '0, 1'b0, '0, 1'b0));     // armed at reset
    send_req(mk_req(OP_SET, '0, '1, 1'b1, '1, 1'b1));            // null breakpoint
    send_req(mk_req(OP_SET, '1, '1, 1'b0, '0, 1'b0));            // zero count acts as one
    send_req(mk_req(OP_EXEC, '1, '0, 1'b0, '0, 1'b0));           // wrong depth
    send_req(mk_req(OP_EXEC, '1, '1, 1'b0, '0, 1'b0));
    send_req(mk_req(OP_SET, 32'h1000, '0, 1'b1, 16'd2, 1'b1));
    send_req(mk_req(OP_EXEC, 32'h1000, 16'd5, 1'b0, '0, 1'b0));
    send_req(mk_req(OP_EXEC, 32'h1000, 16'h1234, 1'b0, '0, 1'b0));
    send_req(mk_req(OP_SET, '1, '0, 1'b1, '1, 1'b0));            // replace existing
    send_req(mk_req(OP_STEP, '0, '0, 1'b0, '0, 1'b0));
    send_req(mk_req(OP_EXEC, '1, '1, 1'b0, '0, 1'b0));           // step beats the table
    send_req(mk_req(OP_UNDEF, '1, '1, 1'b1, '1, 1'b1));
    // fill the table; the last set finds no room
    for (int i = 0; i < 16; i++)
      send_req(mk_req(OP_SET, addr_pool[i], '0, 1'b1, 16'd1, 1'b1));

    // random part in bursts
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++)
        send_req(random_req());
      sent += burst;
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // let the count from the last transfer settle before polling it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
